>>> hdl/spiral_potential_force_eval_assert.svh
// Assertion macros for the spiral potential checker file.
`ifndef SPIRAL_POTENTIAL_FORCE_EVAL_ASSERT_SVH
`define SPIRAL_POTENTIAL_FORCE_EVAL_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define SPFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition leads to a property in the next cycle.
`define SPFE_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) cond |=> prop) else $error(msg);

`endif

>>> hdl/spfe_pkg.sv
// Shared types, constants and arithmetic helpers for the spiral potential evaluator.
package spfe_pkg;

  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned SIN_STEPS  = 5;
  localparam int unsigned PIPE_DEPTH = 13 + DIV_STEPS;

  typedef enum logic [2:0] {
    REG_ARM_COUNT         = 3'd0,
    REG_RADIAL_WAVENUMBER = 3'd1,
    REG_WAVE_AMPLITUDE    = 3'd2,
    REG_PATTERN_SPEED     = 3'd3,
    REG_PHASE_OFFSET      = 3'd4
  } cfg_reg_e;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [30:0] SIN_A11 = 31'd3864;
  // Horner coefficients of sin(pi/2*x), innermost first
  localparam logic [30:0] SIN_COEF [SIN_STEPS] = '{
    31'd172272, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
  };
  localparam logic signed [31:0] TWOPI_Q28 = 32'sd1686629713;
  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [30:0] x;
    logic [30:0] x2;
    logic [30:0] t;
    logic        neg;
  } sin_lane_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] dlo;
    logic [31:0] quo;
    logic [31:0] rad;
    logic        neg;
    logic        pos;
    logic        ovf;
    logic        rz;
    logic [31:0] pot;
    logic [31:0] frad;
  } div_t;

  function automatic logic [31:0] sat32(input logic signed [69:0] v);
    if (v > 70'sd2147483647) begin
      return S32_MAX;
    end else if (v < -70'sd2147483648) begin
      return S32_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic [30:0] horner(input logic [30:0] c, input logic [30:0] x2,
                                         input logic [30:0] t);
    logic [61:0] p;
    p = x2 * t;
    return c - p[60:30];
  endfunction

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  function automatic div_t div_step(input div_t d);
    div_t        n;
    logic [32:0] tr;
    n  = d;
    tr = {d.rem, d.dlo[31]};
    if (tr >= {1'b0, d.rad}) begin
      n.rem = 32'(tr - {1'b0, d.rad});
      n.quo = {d.quo[30:0], 1'b1};
    end else begin
      n.rem = tr[31:0];
      n.quo = {d.quo[30:0], 1'b0};
    end
    n.dlo = {d.dlo[30:0], 1'b0};
    return n;
  endfunction

endpackage

>>> hdl/spiral_potential_force_eval.sv
// Pipelined evaluator of a rotating spiral-arm potential and its forces at one point.
//
//  channel   | dir | fields (low bit up)
//  ----------+-----+-------------------------------------------------------
//  cfg       | in  | cfg_index_i, cfg_data_i (register write, always ready)
//  s_axis    | in  | tdata: radius[31:0] azimuth[47:32] sim_time[79:48]
//  m_axis    | out | tdata: potential[31:0] radial[63:32] azimuthal[95:64]
//            |     | tuser: radius_zero
//
// One beat per cycle enters while the output is not stalled; the 32-step restoring
// divider that forms the azimuthal force sits behind the 7-stage sine/cosine polynomial.
// The whole pipeline holds when the output register is full and not taken.
// Reset clears the valid bits and loads the register defaults.
module spiral_potential_force_eval (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // radius, azimuth, sim_time
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // potential_value, radial_force, azimuthal_force
  output logic [0:0]  m_axis_tuser    // radius_zero
);

  localparam int unsigned NS = spfe_pkg::SIN_STEPS;
  localparam int unsigned ND = spfe_pkg::DIV_STEPS;
  localparam int unsigned NP = spfe_pkg::PIPE_DEPTH;

  // configuration registers
  logic [5:0]         arm_q;
  logic signed [31:0] k_q, amp_q, spd_q;
  logic [15:0]        off_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_q <= 6'd2;
      k_q   <= '0;
      amp_q <= '0;
      spd_q <= '0;
      off_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (spfe_pkg::cfg_reg_e'(cfg_index_i))
        spfe_pkg::REG_ARM_COUNT:         arm_q <= cfg_data_i[5:0];
        spfe_pkg::REG_RADIAL_WAVENUMBER: k_q   <= cfg_data_i;
        spfe_pkg::REG_WAVE_AMPLITUDE:    amp_q <= cfg_data_i;
        spfe_pkg::REG_PATTERN_SPEED:     spd_q <= cfg_data_i;
        spfe_pkg::REG_PHASE_OFFSET:      off_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic          en;
  logic [NP-1:0] vld_q;

  assign en            = !vld_q[NP-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[NP-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NP-2:0], s_axis_tvalid};
    end
  end

  // stage 1: time, radial and wavenumber products
  logic [31:0]        in_rad, in_time;
  logic [15:0]        in_phi;
  logic signed [64:0] st_prod, kr_prod;
  logic signed [63:0] gk_prod;
  logic [31:0]        p1_st_q, p1_kr_q, p1_rad_q;
  logic signed [63:0] p1_gk_q;
  logic [15:0]        p1_phi_q;

  assign in_rad  = s_axis_tdata[31:0];
  assign in_phi  = s_axis_tdata[47:32];
  assign in_time = s_axis_tdata[79:48];
  assign st_prod = spd_q * $signed({1'b0, in_time});
  assign kr_prod = k_q * $signed({1'b0, in_rad});
  assign gk_prod = k_q * spfe_pkg::TWOPI_Q28;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_st_q  <= st_prod[47:16];
      p1_kr_q  <= kr_prod[39:8];
      p1_gk_q  <= gk_prod;
      p1_phi_q <= in_phi;
      p1_rad_q <= in_rad;
    end
  end

  // stage 2: phase sum, 2*pi*k rounding
  logic [31:0]        ph_diff, phase;
  logic [37:0]        ph_mul;
  logic signed [63:0] gk_rnd;
  logic [31:0]        p2_phase_q, p2_rad_q;
  logic signed [34:0] p2_g_q;

  assign ph_diff = {p1_phi_q, 16'b0} - p1_st_q;
  assign ph_mul  = arm_q * ph_diff;
  assign phase   = ph_mul[31:0] + p1_kr_q + {off_q, 16'b0};
  assign gk_rnd  = p1_gk_q + 64'sd134217728;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_phase_q <= phase;
      p2_g_q     <= gk_rnd[62:28];
      p2_rad_q   <= p1_rad_q;
    end
  end

  // sine stages: lane 0 is sine, lane 1 is cosine (phase plus a quarter turn)
  spfe_pkg::sin_lane_t sn_q [NS+1][2];
  logic signed [34:0]  sg_q [NS+1];
  logic [31:0]         sr_q [NS+1];
  logic [31:0]         lane_ph [2];
  logic [30:0]         lane_x  [2];
  logic [61:0]         lane_sq [2];

  assign lane_ph[0] = p2_phase_q;
  assign lane_ph[1] = p2_phase_q + 32'h4000_0000;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      lane_x[l]  = lane_ph[l][30] ? spfe_pkg::Q30_ONE - {1'b0, lane_ph[l][29:0]}
                                  : {1'b0, lane_ph[l][29:0]};
      lane_sq[l] = lane_x[l] * lane_x[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        sn_q[0][l] <= '{x: lane_x[l], x2: lane_sq[l][60:30], t: spfe_pkg::SIN_A11,
                        neg: lane_ph[l][31]};
      end
      sg_q[0] <= p2_g_q;
      sr_q[0] <= p2_rad_q;
    end
  end

  for (genvar i = 1; i <= NS; i++) begin : g_horner
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int l = 0; l < 2; l++) begin
          sn_q[i][l] <= '{x: sn_q[i-1][l].x, x2: sn_q[i-1][l].x2,
                          t: spfe_pkg::horner(spfe_pkg::SIN_COEF[i-1], sn_q[i-1][l].x2,
                                              sn_q[i-1][l].t),
                          neg: sn_q[i-1][l].neg};
        end
        sg_q[i] <= sg_q[i-1];
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  // stage 9: final multiply by x, clamp and sign
  logic [61:0]        fin_prod [2];
  logic [30:0]        fin_mag  [2];
  logic signed [31:0] p9_s_q   [2];
  logic signed [34:0] p9_g_q;
  logic [31:0]        p9_rad_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      fin_prod[l] = sn_q[NS][l].x * sn_q[NS][l].t;
      fin_mag[l]  = (fin_prod[l][60:30] > spfe_pkg::Q30_ONE) ? spfe_pkg::Q30_ONE
                                                             : fin_prod[l][60:30];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        p9_s_q[l] <= sn_q[NS][l].neg ? -$signed({1'b0, fin_mag[l]})
                                     : $signed({1'b0, fin_mag[l]});
      end
      p9_g_q   <= sg_q[NS];
      p9_rad_q <= sr_q[NS];
    end
  end

  // stage 10: amplitude products
  logic signed [63:0] amp_sin, amp_cos, rnd_sin, rnd_cos;
  logic [31:0]        p10_pot_q, p10_rad_q;
  logic signed [32:0] p10_w_q;
  logic signed [34:0] p10_g_q;

  assign amp_sin = amp_q * p9_s_q[0];
  assign amp_cos = amp_q * p9_s_q[1];
  assign rnd_sin = amp_sin + 64'sd536870912;
  assign rnd_cos = amp_cos + 64'sd536870912;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p10_pot_q <= spfe_pkg::sat32(70'(rnd_cos >>> 30));
      p10_w_q   <= rnd_sin[62:30];
      p10_g_q   <= p9_g_q;
      p10_rad_q <= p9_rad_q;
    end
  end

  // stage 11: split radial product, arm-count product
  logic signed [50:0] pp_lo, pp_hi;
  logic signed [39:0] num;
  logic signed [50:0] p11_lo_q, p11_hi_q;
  logic signed [39:0] p11_num_q;
  logic [31:0]        p11_pot_q, p11_rad_q;

  assign pp_lo = $signed({1'b0, p10_g_q[16:0]}) * p10_w_q;
  assign pp_hi = $signed(p10_g_q[34:17]) * p10_w_q;
  assign num   = $signed({1'b0, arm_q}) * p10_w_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p11_lo_q  <= pp_lo;
      p11_hi_q  <= pp_hi;
      p11_num_q <= num;
      p11_pot_q <= p10_pot_q;
      p11_rad_q <= p10_rad_q;
    end
  end

  // stage 12: radial force, divider setup
  logic signed [69:0] rad_sum, rad_rnd;
  logic [39:0]        num_abs;
  spfe_pkg::div_t     div_init;
  spfe_pkg::div_t     div_q [ND+1];

  assign rad_sum = (70'(p11_hi_q) <<< 17) + 70'(p11_lo_q);
  assign rad_rnd = rad_sum + 70'sd8388608;
  assign num_abs = p11_num_q[39] ? 40'(-p11_num_q) : 40'(p11_num_q);

  always_comb begin
    div_init.rem  = {9'b0, num_abs[38:16]};
    div_init.dlo  = {num_abs[15:0], 16'b0};
    div_init.quo  = '0;
    div_init.rad  = p11_rad_q;
    div_init.neg  = p11_num_q[39];
    div_init.pos  = !p11_num_q[39] && (p11_num_q != '0);
    // quotient would reach 2^32: saturate without dividing
    div_init.ovf  = {9'b0, num_abs[38:0]} >= {p11_rad_q, 16'b0};
    div_init.rz   = (p11_rad_q == '0);
    div_init.pot  = p11_pot_q;
    div_init.frad = spfe_pkg::sat32(rad_rnd >>> 24);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_q[0] <= div_init;
    end
  end

  for (genvar i = 0; i < ND; i++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en) begin
        div_q[i+1] <= spfe_pkg::div_step(div_q[i]);
      end
    end
  end

  // output register
  spfe_pkg::div_t dv;
  logic [31:0]    faz;
  logic [95:0]    out_data_q;
  logic           out_rz_q;

  assign dv = div_q[ND];

  always_comb begin
    if (dv.rz) begin
      faz = dv.pos ? spfe_pkg::S32_MAX : (dv.neg ? spfe_pkg::S32_MIN : '0);
    end else if (!dv.neg) begin
      faz = (dv.ovf || dv.quo[31]) ? spfe_pkg::S32_MAX : dv.quo;
    end else begin
      faz = (dv.ovf || (dv.quo[31] && (dv.quo[30:0] != '0))) ? spfe_pkg::S32_MIN
                                                             : -dv.quo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {faz, dv.frad, dv.pot};
      out_rz_q   <= dv.rz;
    end
  end

  assign m_axis_tdata = out_data_q;
  assign m_axis_tuser = out_rz_q;

endmodule

>>> hdl/spfe_checker.sv
// Port-level checker for the spiral potential evaluator, bound to the top level.
`include "spiral_potential_force_eval_assert.svh"

module spfe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  `SPFE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output beat dropped or changed while stalled")

  `SPFE_ASSERT(a_stall_ready, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready does not follow output stall")

  `SPFE_ASSERT(a_zero_rad_sat, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[95:64] == 32'h7FFF_FFFF || m_axis_tdata[95:64] == 32'h8000_0000 || m_axis_tdata[95:64] == 32'h0, "zero radius azimuthal force not saturated")

endmodule

bind spiral_potential_force_eval spfe_checker u_spfe_checker (.*);

>>> tb/sv/tb_spiral_potential_force_eval.sv
// Self-checking testbench for the spiral potential and force evaluator.
`timescale 1ns / 100ps

module tb_spiral_potential_force_eval;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES   = 2 * spfe_pkg::PIPE_DEPTH;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam logic [2:0]  REG_UNUSED     = 3'd7;

  typedef struct packed {
    logic [31:0] pot;
    logic [31:0] frad;
    logic [31:0] faz;
    logic        rz;
  } force_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [95:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  // Local copy of the register file
  logic [5:0]  arms_q;
  logic [31:0] wavenum_q;
  logic [31:0] amp_q;
  logic [31:0] speed_q;
  logic [15:0] phase0_q;

  force_result_t expected_forces[$];
  int unsigned   error_count;
  int unsigned   items_sent;
  int unsigned   results_seen;
  int unsigned   zero_radius_seen;
  int unsigned   cfg_writes;
  bit            tx_gaps;
  bit            rx_stalls;
  bit            rx_hold;

  spiral_potential_force_eval dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint rnd_shift(input longint v, input int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return spfe_pkg::S32_MAX;
    if (v < -64'sd2147483648) return spfe_pkg::S32_MIN;
    return v[31:0];
  endfunction

  // Signed Q2.30 sine of a Q0.32 turn fraction
  function automatic longint turn_sine(input logic [31:0] p);
    longint unsigned x, x2, acc;
    x = {34'd0, p[29:0]};
    if (p[30]) x = 64'd1073741824 - x;
    x2  = (x * x) >> 30;
    acc = {33'd0, spfe_pkg::SIN_A11};
    for (int i = 0; i < spfe_pkg::SIN_STEPS; i++) begin
      acc = longint'(spfe_pkg::SIN_COEF[i]) - ((x2 * acc) >> 30);
    end
    acc = (x * acc) >> 30;
    if (acc > 64'd1073741824) acc = 64'd1073741824;
    return p[31] ? -longint'(acc) : longint'(acc);
  endfunction

  function automatic force_result_t eval_point(input logic [31:0] r, input logic [15:0] az,
                                               input logic [31:0] t);
    force_result_t   res;
    logic [63:0]     st_prod, kr_prod;
    logic [31:0]     ph;
    longint          k, amp, m, sn, cs, w, g, num;
    longint unsigned ug, uw, un, quo;
    k       = longint'($signed(wavenum_q));
    amp     = longint'($signed(amp_q));
    m       = longint'({58'd0, arms_q});
    st_prod = longint'($signed(speed_q)) * longint'({32'd0, t});
    kr_prod = k * longint'({32'd0, r});
    ph      = ({az, 16'd0} - st_prod[47:16]) * {26'd0, arms_q};
    ph      = ph + kr_prod[39:8] + {phase0_q, 16'd0};
    sn      = turn_sine(ph);
    cs      = turn_sine(ph + 32'h4000_0000);
    res.pot = clamp32(rnd_shift(amp * cs, 30));
    w       = rnd_shift(amp * sn, 30);
    g       = rnd_shift(k * longint'(spfe_pkg::TWOPI_Q28), 28);
    ug      = (g < 0) ? -g : g;
    uw      = (w < 0) ? -w : w;
    if (uw != 0 && ug > (64'd1 << 62) / uw) begin
      res.frad = ((g < 0) != (w < 0)) ? spfe_pkg::S32_MIN : spfe_pkg::S32_MAX;
    end else begin
      res.frad = clamp32(rnd_shift(g * w, 24));
    end
    num    = m * w;
    res.rz = (r == 32'd0);
    if (res.rz) begin
      res.faz = (num > 0) ? spfe_pkg::S32_MAX : ((num < 0) ? spfe_pkg::S32_MIN : 32'd0);
    end else begin
      un      = (num < 0) ? -num : num;
      quo     = (un << 16) / {32'd0, r};
      res.faz = clamp32((num < 0) ? -longint'(quo) : longint'(quo));
    end
    return res;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return $urandom_range(1, 3);
    if (sel < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return spfe_pkg::S32_MIN;
      3: return spfe_pkg::S32_MAX;
      4: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    while (expected_forces.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Write one register; only called with the pipeline drained
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    wait_drained();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      spfe_pkg::REG_ARM_COUNT:         arms_q    = val[5:0];
      spfe_pkg::REG_RADIAL_WAVENUMBER: wavenum_q = val;
      spfe_pkg::REG_WAVE_AMPLITUDE:    amp_q     = val;
      spfe_pkg::REG_PATTERN_SPEED:     speed_q   = val;
      spfe_pkg::REG_PHASE_OFFSET:      phase0_q  = val[15:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic load_setting(input logic [5:0] m, input logic [31:0] k, input logic [31:0] a,
                              input logic [31:0] s, input logic [15:0] p0);
    write_reg(spfe_pkg::REG_ARM_COUNT, {26'd0, m});
    write_reg(spfe_pkg::REG_RADIAL_WAVENUMBER, k);
    write_reg(spfe_pkg::REG_WAVE_AMPLITUDE, a);
    write_reg(spfe_pkg::REG_PATTERN_SPEED, s);
    write_reg(spfe_pkg::REG_PHASE_OFFSET, {16'd0, p0});
  endtask

  task automatic send_point(input logic [31:0] r, input logic [15:0] az, input logic [31:0] t);
    if (tx_gaps && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap_len()) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {t, az, r};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_forces.push_back(eval_point(r, az, t));
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_random(input int unsigned count);
    logic [31:0] r;
    for (int i = 0; i < count; i++) begin
      r = ($urandom_range(0, 19) == 0) ? 32'd0 : pick32();
      send_point(r, 16'($urandom), pick32());
    end
    s_axis_tvalid = 1'b0;
  endtask

  task automatic test_reset_values();
    send_point(32'h0001_0000, 16'h4000, 32'd0);
    send_point(32'd0, 16'd0, 32'hFFFF_FFFF);
    send_point(32'hFFFF_FFFF, 16'hFFFF, 32'h0003_0000);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic test_field_extremes();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    load_setting(6'd1, 32'h0100_0000, 32'h0001_0000, 32'h0000_0000, 16'h0000);
    send_point(32'd0, 16'h0000, 32'd0);
    send_point(32'd0, 16'h4000, 32'd0);
    send_point(32'd1, 16'hC000, 32'd0);
    send_point(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_point(32'h0000_8000, 16'h2000, 32'h0001_0000);
    s_axis_tvalid = 1'b0;
    // no azimuthal term, full offset, fastest negative pattern
    load_setting(6'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
    send_point(32'd0, 16'h1234, 32'h0001_0000);
    send_point(32'h0001_0000, 16'hFFFF, 32'hFFFF_FFFF);
    send_point(32'h0000_0001, 16'h8000, 32'h0000_0001);
    s_axis_tvalid = 1'b0;
    // radial product overflow and saturated azimuthal force
    load_setting(6'd63, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h4000);
    send_point(32'd0, 16'h0100, 32'd0);
    send_point(32'd1, 16'h0100, 32'h0000_4000);
    send_point(32'hFFFF_FFFF, 16'h0000, 32'hFFFF_FFFF);
    send_point(32'h0000_0002, 16'hFFFF, 32'h8000_0000);
    s_axis_tvalid = 1'b0;
    load_setting(6'd32, 32'hFF00_0000, 32'h0100_0000, 32'h0000_1000, 16'h8000);
    send_point(32'd0, 16'h0000, 32'h0000_0000);
    send_point(32'h0000_0100, 16'h3FFF, 32'h0010_0000);
    send_point(32'h0100_0000, 16'hBFFF, 32'h7FFF_FFFF);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic test_output_backpressure();
    load_setting(6'd2, 32'h0080_0000, 32'h0004_0000, 32'h0100_0000, 16'h1000);
    tx_gaps = 1'b0;
    rx_hold = 1'b1;
    send_random(120);
    tx_gaps = 1'b1;
  endtask

  task automatic test_sender_pause();
    send_random(30);
    while (expected_forces.size() != 0) @(negedge clk_i);
    send_random(30);
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 6; ph++) begin
      load_setting(6'($urandom), pick32(), pick32(), pick32(), 16'($urandom));
      rx_stalls = (ph != 2);
      tx_gaps   = (ph != 2) && (ph != 4);
      send_random(140);
    end
    rx_stalls = 1'b1;
    tx_gaps   = 1'b1;
  endtask

  // Receiver: random stalls plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        rx_hold = 1'b0;
      end else if (rst_ni && rx_stalls && $urandom_range(0, 3) == 0) begin
        m_axis_tready = 1'b0;
        repeat (gap_len()) @(negedge clk_i);
      end
      m_axis_tready = rst_ni;
    end
  end

  always @(posedge clk_i) begin
    force_result_t exp_res, act;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64], m_axis_tuser[0]};
      results_seen++;
      if (act.rz) zero_radius_seen++;
      if (expected_forces.size() == 0) begin
        $display("%0t: unexpected beat %h", $realtime, act);
        error_count++;
      end else begin
        exp_res = expected_forces.pop_front();
        if (act.pot !== exp_res.pot) begin
          $display("%0t: potential exp %h got %h", $realtime, exp_res.pot, act.pot);
          error_count++;
        end
        if (act.frad !== exp_res.frad) begin
          $display("%0t: radial force exp %h got %h", $realtime, exp_res.frad, act.frad);
          error_count++;
        end
        if (act.faz !== exp_res.faz) begin
          $display("%0t: azimuthal force exp %h got %h", $realtime, exp_res.faz, act.faz);
          error_count++;
        end
        if (act.rz !== exp_res.rz) begin
          $display("%0t: radius zero exp %b got %b", $realtime, exp_res.rz, act.rz);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: watchdog expired, %0d results pending", $realtime, expected_forces.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = spfe_pkg::REG_ARM_COUNT;
    cfg_data_i    = 32'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    arms_q        = 6'd2;
    wavenum_q     = 32'd0;
    amp_q         = 32'd0;
    speed_q       = 32'd0;
    phase0_q      = 16'd0;
    tx_gaps       = 1'b1;
    rx_stalls     = 1'b1;
    rx_hold       = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_values();
    test_field_extremes();
    test_output_backpressure();
    test_sender_pause();
    test_random_settings();

    wait_drained();
    $display("Sent %0d points, checked %0d results (%0d at zero radius), %0d register writes",
             items_sent, results_seen, zero_radius_seen, cfg_writes);
    $display("Covered field extremes, saturation, output hold-off and random settings");
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
